// ----- src/spbs_pkg.sv -----
// ---------------------------------------------------------------------------
// spbs_pkg: shared types and codes of the sparse paged bitmap store.
// Opcodes, result status codes and the coordinate width used by the
// front part.
// ---------------------------------------------------------------------------
package spbs_pkg;

  localparam int CoordW = 32;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic {
    ST_DONE = 1'b0,
    ST_FULL = 1'b1
  } status_t;

endpackage

// ----- src/spbs_if.sv -----
// ---------------------------------------------------------------------------
// spbs_if: valid/ready channel carrying a generic payload.
// The source drives valid and the payload, the sink drives ready.
// ---------------------------------------------------------------------------
interface spbs_if #(
  parameter int W = 1
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/sparse_paged_bitmap_store.sv -----
// ---------------------------------------------------------------------------
// sparse_paged_bitmap_store: sparse 2-D bit store over signed coordinates.
// Top level joining the classifying front part and the memory back part.
// ---------------------------------------------------------------------------
// Usage: the in_ channel takes one request (opcode, cell_x, cell_y) when
// in_valid and in_ready are high at a clock edge. Read returns the cell,
// set makes it alive (allocating a cleared page if needed), clear makes it
// dead. The out_ channel delivers one result (alive, status) per request in
// order; status 1 means the page table was full and the set was dropped.
// The front part matches the page key in its page table and allocates
// there; a two-entry queue feeds the back part, which reads the page word
// and then writes it back. The back part finishes one request before it
// takes the next, set by the read-then-write of the single page memory
// port.
// Synchronous active-low reset empties the page table and queues; no
// clearing pass is needed since a page is cleared when allocated.
// When out_ready is low, the result holds, the back part waits, the queue
// fills and in_ready falls.
// ---------------------------------------------------------------------------
module sparse_paged_bitmap_store #(
  parameter int PAGE_SIDE = 16,
  parameter int MAX_PAGES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          in_opcode,
  input  logic signed [31:0]  in_cell_x,
  input  logic signed [31:0]  in_cell_y,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_alive,
  output logic                out_status,
  output logic                out_valid,
  input  logic                out_ready
);
  import spbs_pkg::*;

  localparam int IdxW  = $clog2(PAGE_SIDE * PAGE_SIDE);
  localparam int SlotW = $clog2(MAX_PAGES);
  localparam int QW    = 2 + 1 + 1 + SlotW + IdxW;

  spbs_if #(.W(QW)) q_ch ();

  spbs_front #(.PAGE_SIDE(PAGE_SIDE), .MAX_PAGES(MAX_PAGES)) u_front (
    .clk, .rst_n, .in_opcode, .in_cell_x, .in_cell_y, .in_valid, .in_ready,
    .q_out(q_ch.source)
  );

  spbs_back #(.PAGE_SIDE(PAGE_SIDE), .MAX_PAGES(MAX_PAGES)) u_back (
    .clk, .rst_n, .q_in(q_ch.sink), .out_alive, .out_status, .out_valid,
    .out_ready
  );
endmodule

// ----- src/spbs_front.sv -----
// ---------------------------------------------------------------------------
// spbs_front: accepts requests, splits the coordinates into page key and
// in-page offset, and matches the key against the page table.
// Page keys and the valid bits live here; a new page is allocated here too,
// so the next request already sees it.
// ---------------------------------------------------------------------------
module spbs_front #(
  parameter int PAGE_SIDE = 16,
  parameter int MAX_PAGES = 64,
  localparam int OffW  = $clog2(PAGE_SIDE),
  localparam int IdxW  = $clog2(PAGE_SIDE * PAGE_SIDE),
  localparam int SlotW = $clog2(MAX_PAGES),
  localparam int CntW  = $clog2(MAX_PAGES + 1),
  localparam int KeyW  = 2 * (spbs_pkg::CoordW - OffW + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           in_opcode,
  input  logic signed [31:0]   in_cell_x,
  input  logic signed [31:0]   in_cell_y,
  input  logic                 in_valid,
  output logic                 in_ready,
  spbs_if.source               q_out
);
  import spbs_pkg::*;

  localparam int PKW = KeyW / 2;

  // Stage 1: registered request with split coordinates.
  logic            s1_valid_r;
  logic [1:0]      s1_op_r;
  logic [KeyW-1:0] s1_key_r;
  logic [IdxW-1:0] s1_idx_r;

  logic [PKW-1:0]  px, py;
  logic [OffW-1:0] ox, oy;

  // Floor division by a power of two is an arithmetic shift; the offset is
  // the low bits, which are never negative.
  always_comb begin
    px = PKW'(in_cell_x >>> OffW);
    py = PKW'(in_cell_y >>> OffW);
    ox = in_cell_x[OffW-1:0];
    oy = in_cell_y[OffW-1:0];
  end

  logic [KeyW-1:0]   key_r [MAX_PAGES];
  logic [MAX_PAGES-1:0] pvalid_r;
  logic [CntW-1:0]   used_r;

  logic             s1_go;
  logic [MAX_PAGES-1:0] hit_vec;
  logic             hit;
  logic [SlotW-1:0] hit_slot;
  logic             full;

  always_comb begin
    for (int i = 0; i < MAX_PAGES; i++) begin
      hit_vec[i] = pvalid_r[i] && (key_r[i] == s1_key_r);
    end
    hit = |hit_vec;
    hit_slot = '0;
    for (int i = 0; i < MAX_PAGES; i++) begin
      if (hit_vec[i]) hit_slot = SlotW'(i);
    end
    full = (used_r == CntW'(MAX_PAGES));
  end

  logic             alloc;
  logic             drop_full;
  logic             found;
  logic [SlotW-1:0] slot;

  always_comb begin
    alloc     = (s1_op_r == OP_SET) && !hit && !full;
    drop_full = (s1_op_r == OP_SET) && !hit && full;
    found     = hit || alloc;
    slot      = hit ? hit_slot : SlotW'(used_r);
  end

  assign s1_go    = s1_valid_r && q_out.ready;
  assign in_ready = !s1_valid_r || q_out.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      pvalid_r   <= '0;
      used_r     <= '0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (s1_go && alloc) begin
        pvalid_r[slot] <= 1'b1;
        used_r         <= used_r + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_op_r  <= in_opcode;
      s1_key_r <= {px, py};
      s1_idx_r <= IdxW'({oy, ox});
    end
    if (s1_go && alloc) key_r[slot] <= s1_key_r;
  end

  // Queue entry: op, found, fresh-page-or-full flag, slot, bit index.
  assign q_out.valid = s1_valid_r;
  assign q_out.data  = {s1_op_r, found, alloc || drop_full, slot, s1_idx_r};

`ifndef SYNTH
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CntW'(MAX_PAGES)) else $error("page count overflow");
  a_alloc_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && alloc) |=> used_r == $past(used_r) + CntW'(1))
    else $error("allocation did not count");
  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> $onehot0(hit_vec)) else $error("duplicate page key");
`endif
endmodule

// ----- src/spbs_back.sv -----
// ---------------------------------------------------------------------------
// spbs_back: carries out requests on the page bit memory.
// A two-entry queue takes requests from the front part; each request does
// a read of one page word, writes it back if the page was found, and leaves one result.
// ---------------------------------------------------------------------------
module spbs_back #(
  parameter int PAGE_SIDE = 16,
  parameter int MAX_PAGES = 64,
  localparam int IdxW  = $clog2(PAGE_SIDE * PAGE_SIDE),
  localparam int SlotW = $clog2(MAX_PAGES),
  localparam int QW    = 2 + 1 + 1 + SlotW + IdxW,
  localparam int BitsW = PAGE_SIDE * PAGE_SIDE
) (
  input  logic   clk,
  input  logic   rst_n,
  spbs_if.sink   q_in,
  output logic   out_alive,
  output logic   out_status,
  output logic   out_valid,
  input  logic   out_ready
);
  import spbs_pkg::*;

  typedef enum logic [1:0] {
    S_FETCH = 2'b01,
    S_WRITE = 2'b10
  } bstate_t;

  // Two-entry request queue.
  logic [QW-1:0] fifo_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          push, pop;

  assign q_in.ready = (cnt_r != 2'd2);
  assign push = q_in.valid && q_in.ready;

  bstate_t       st_r;
  logic [QW-1:0] cur_r;
  logic [BitsW-1:0] page_mem [MAX_PAGES];
  logic [BitsW-1:0] rd_r;

  logic [1:0]       c_op;
  logic             c_found, c_flag;
  logic [SlotW-1:0] c_slot;
  logic [IdxW-1:0]  c_idx;
  assign {c_op, c_found, c_flag, c_slot, c_idx} = cur_r;

  logic out_free;
  assign out_free = !out_valid || out_ready;
  assign pop = (st_r == S_FETCH) && (cnt_r != 2'd0);

  logic [BitsW-1:0] base, word;
  logic             fresh, full_drop, bit_now, alive_nxt;

  always_comb begin
    fresh     = c_found && c_flag;
    full_drop = !c_found && c_flag;
    base      = fresh ? '0 : rd_r;
    word      = base;
    bit_now   = c_found && base[c_idx];
    alive_nxt = bit_now;
    unique case (c_op)
      OP_SET: begin
        if (c_found) word[c_idx] = 1'b1;
        alive_nxt = c_found;
      end
      OP_CLEAR: begin
        word[c_idx] = 1'b0;
        alive_nxt   = 1'b0;
      end
      default: alive_nxt = bit_now;
    endcase
  end

  logic fin;
  assign fin = (st_r == S_WRITE) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
      st_r <= S_FETCH; out_valid <= 1'b0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
      if (fin) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (st_r)
        S_FETCH: if (pop) st_r <= S_WRITE;
        S_WRITE: if (fin) st_r <= S_FETCH;
        default: st_r <= S_FETCH;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo_r[wp_r] <= q_in.data;
    if (pop) cur_r <= fifo_r[rp_r];
    if (pop) rd_r <= page_mem[fifo_r[rp_r][IdxW +: SlotW]];
    if (fin && c_found) page_mem[c_slot] <= word;
    if (fin) begin
      out_alive  <= alive_nxt;
      out_status <= full_drop ? ST_FULL : ST_DONE;
    end
  end

`ifndef SYNTH
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("queue overrun");
  a_full_dead: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> !out_alive) else $error("full but alive");
  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    fin |=> out_valid) else $error("result lost");
`endif
endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: testbench of the sparse paged bitmap store.
// Requests go in on a valid/ready channel and results come back in order.
// A page-table model predicts alive and status for each accepted request.
// Directed checks cover the coordinate extremes, every opcode, absent pages
// and the full table. Random traffic covers a dense region under several
// idle patterns, a long output stall and a drain pause.
// ---------------------------------------------------------------------------
module tb;
  import spbs_pkg::*;

  localparam int ClkHalf   = 4;
  localparam int SideBits  = 4;
  localparam int PageLimit = 64;
  localparam int WatchMax  = 20000;

  typedef struct packed {
    logic alive;
    logic status;
  } cell_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  spbs_if #(.W(66)) in_ch ();
  spbs_if #(.W(2))  out_ch ();

  sparse_paged_bitmap_store dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_opcode  (in_ch.data[65:64]),
    .in_cell_x  (in_ch.data[63:32]),
    .in_cell_y  (in_ch.data[31:0]),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_alive  (out_ch.data[1]),
    .out_status (out_ch.data[0]),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready)
  );

  always #ClkHalf clk = ~clk;

  // Model state: page key {page x, page y} to the page's cell bits.
  logic [255:0] page_cells [logic [55:0]];
  int           pages_alloc = 0;
  cell_result_t pending_results [$];

  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
  end

  function automatic cell_result_t predict_cell(opcode_t op, logic signed [31:0] x,
                                                logic signed [31:0] y);
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [55:0]        key;
    logic [7:0]         idx;
    cell_result_t       res;
    px  = x >>> SideBits;
    py  = y >>> SideBits;
    key = {px[27:0], py[27:0]};
    idx = {y[3:0], x[3:0]};
    res = '{alive: 1'b0, status: ST_DONE};
    unique case (op)
      OP_SET: begin
        if (!page_cells.exists(key)) begin
          if (pages_alloc < PageLimit) begin
            page_cells[key] = '0;
            pages_alloc++;
          end else begin
            res.status = ST_FULL;
          end
        end
        if (page_cells.exists(key)) begin
          page_cells[key][idx] = 1'b1;
          res.alive = 1'b1;
        end
      end
      OP_CLEAR: begin
        if (page_cells.exists(key)) page_cells[key][idx] = 1'b0;
      end
      default: begin
        if (page_cells.exists(key)) res.alive = page_cells[key][idx];
      end
    endcase
    return res;
  endfunction

  task automatic send_request(opcode_t op, logic signed [31:0] x, logic signed [31:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= {op, x, y};
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(predict_cell(op, x, y));
  endtask

  function automatic opcode_t rand_op();
    int r;
    r = $urandom_range(99);
    if (r < 40) return OP_SET;
    if (r < 60) return OP_CLEAR;
    if (r < 95) return OP_READ;
    return OP_NONE;
  endfunction

  // Mostly a dense region of 36 pages, now and then a corner of the range.
  function automatic logic signed [31:0] local_coord();
    int r;
    r = $urandom_range(99);
    if (r == 0) return 32'sh8000_0000;
    if (r == 1) return 32'sh7fff_ffff;
    return $signed($urandom_range(95)) - 48;
  endfunction

  task automatic test_directed();
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    lo = 32'sh8000_0000;
    hi = 32'sh7fff_ffff;
    send_request(OP_READ, 0, 0);
    send_request(OP_CLEAR, 5, 5);
    send_request(OP_SET, 0, 0);
    send_request(OP_READ, 0, 0);
    send_request(OP_NONE, 0, 0);
    send_request(OP_CLEAR, 0, 0);
    send_request(OP_READ, 0, 0);
    send_request(OP_SET, lo, lo);
    send_request(OP_SET, hi, hi);
    send_request(OP_SET, lo, hi);
    send_request(OP_SET, hi, lo);
    send_request(OP_READ, lo, lo);
    send_request(OP_READ, hi, hi);
    send_request(OP_READ, lo + 1, lo);
    send_request(OP_READ, hi - 1, hi);
    // Negative coordinates use floor division: -1 lies in page -1 at offset 15.
    send_request(OP_SET, -1, -1);
    send_request(OP_READ, -1, -1);
    send_request(OP_READ, 15, 15);
    send_request(OP_SET, -16, -17);
    send_request(OP_READ, -16, -17);
    send_request(OP_READ, -17, -16);
    send_request(OP_NONE, -1, -1);
  endtask

  task automatic test_random_local(int count);
    repeat (count) send_request(rand_op(), local_coord(), local_coord());
  endtask

  task automatic test_pressure();
    hold_req++;
    repeat (30) send_request(rand_op(), local_coord(), local_coord());
    in_ch.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (30) send_request(rand_op(), local_coord(), local_coord());
  endtask

  task automatic test_table_full();
    logic signed [31:0] x;
    logic signed [31:0] y;
    for (int i = 0; i < 30; i++) begin
      x = (1000 + i) * 16 + i % 16;
      y = -(2000 + i) * 16;
      send_request(OP_SET, x, y);
    end
    send_request(OP_SET, 32'sh4000_0000, 32'sh4000_0000);
    send_request(OP_READ, 32'sh4000_0000, 32'sh4000_0000);
    send_request(OP_CLEAR, 32'sh4000_0010, 32'sh4000_0000);
    send_request(OP_SET, 3, 3);
    send_request(OP_READ, 3, 3);
    repeat (300) begin
      if ($urandom_range(1)) send_request(rand_op(), $urandom, $urandom);
      else send_request(rand_op(), local_coord(), local_coord());
    end
  endtask

  // Result side: checks each accepted result, then picks the next ready.
  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result alive=%0b status=%0b", $time,
                 out_ch.data[1], out_ch.data[0]);
        errors++;
      end else begin
        if (out_ch.data[1] !== pending_results[0].alive) begin
          $display("%0t: alive expected %0b actual %0b", $time,
                   pending_results[0].alive, out_ch.data[1]);
          errors++;
        end
        if (out_ch.data[0] !== pending_results[0].status) begin
          $display("%0t: status expected %0b actual %0b", $time,
                   pending_results[0].status, out_ch.data[0]);
          errors++;
        end
        void'(pending_results.pop_front());
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchMax) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 15;
    recv_idle_pct = 49;
    test_directed();
    test_random_local(450);
    test_pressure();
    send_idle_pct = 49;
    recv_idle_pct = 15;
    test_random_local(450);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_table_full();
    in_ch.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
